### hdl/ctc_pkg.sv
// calendar time counter package: item types, time record and month table
// no dependencies; imported by ctc_step and calendar_time_counter
`default_nettype none

package ctc_pkg;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam int FLAG_SEC   = 0;
    localparam int FLAG_MIN   = 1;
    localparam int FLAG_HOUR  = 2;
    localparam int FLAG_DAY   = 3;
    localparam int FLAG_MONTH = 4;
    localparam int FLAG_YEAR  = 5;
    localparam int FLAG_W     = 6;

    localparam logic [FLAG_W-1:0] FLAGS_ALL = '1;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [2:0] WDAY_LAST  = 3'd6;
    localparam logic [3:0] MONTH_LAST = 4'd12;

    typedef struct packed {
        logic        action;
        logic [15:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
        logic [2:0]  set_weekday;
    } in_item_t;

    typedef struct packed {
        logic [15:0]       year_now;
        logic [3:0]        month_now;
        logic [4:0]        day_now;
        logic [4:0]        hour_now;
        logic [5:0]        minute_now;
        logic [5:0]        second_now;
        logic [2:0]        weekday_now;
        logic [FLAG_W-1:0] changed_flags;
    } out_item_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } time_t;

    localparam time_t TIME_RESET = '{
        year: 16'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
        minute: 6'd0, second: 6'd0, weekday: 3'd0
    };

    // months outside 1..12 take the february length
    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic [1:0] year_lo);
        logic [4:0] len;
        begin
            case (month) inside
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                default: len = (year_lo == 2'd0) ? 5'd29 : 5'd28;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/ctc_step.sv
// calendar step logic: next time and changed flags for one item
// depends on ctc_pkg
`default_nettype none

module ctc_step (
    input  var ctc_pkg::time_t    cur,
    input  var ctc_pkg::in_item_t item,
    output ctc_pkg::time_t        nxt,
    output logic [5:0]            flags
);
    import ctc_pkg::*;

    logic [4:0] last_day;

    assign last_day = month_len(cur.month, cur.year[1:0]);

    always_comb
    begin
        nxt   = cur;
        flags = '0;
        if (item.action == ACT_LOAD)
        begin
            nxt.year    = item.set_year;
            nxt.month   = item.set_month;
            nxt.day     = item.set_day;
            nxt.hour    = item.set_hour;
            nxt.minute  = item.set_minute;
            nxt.second  = item.set_second;
            nxt.weekday = item.set_weekday;
            flags       = FLAGS_ALL;
        end
        else
        begin
            flags[FLAG_SEC] = 1'b1;
            if (cur.second >= SEC_LAST)
            begin
                nxt.second      = '0;
                flags[FLAG_MIN] = 1'b1;
                if (cur.minute >= MIN_LAST)
                begin
                    nxt.minute       = '0;
                    flags[FLAG_HOUR] = 1'b1;
                    if (cur.hour >= HOUR_LAST)
                    begin
                        nxt.hour        = '0;
                        flags[FLAG_DAY] = 1'b1;
                        nxt.weekday     = (cur.weekday >= WDAY_LAST) ? 3'd0
                                                                    : cur.weekday + 3'd1;
                        if (cur.day >= last_day)
                        begin
                            nxt.day           = 5'd1;
                            flags[FLAG_MONTH] = 1'b1;
                            if (cur.month >= MONTH_LAST)
                            begin
                                nxt.month        = 4'd1;
                                nxt.year         = cur.year + 16'd1;
                                flags[FLAG_YEAR] = 1'b1;
                            end
                            else
                            begin
                                nxt.month = cur.month + 4'd1;
                            end
                        end
                        else
                        begin
                            nxt.day = cur.day + 5'd1;
                        end
                    end
                    else
                    begin
                        nxt.hour = cur.hour + 5'd1;
                    end
                end
                else
                begin
                    nxt.minute = cur.minute + 6'd1;
                end
            end
            else
            begin
                nxt.second = cur.second + 6'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/calendar_time_counter.sv
// calendar time counter top level: input register, calendar state, result register
// depends on ctc_pkg and ctc_step
//
//   channel | direction | handshake           | payload
//   src     | in        | src_valid/src_stall | src_item (in_item_t)
//   res     | out       | res_valid/res_stall | res_item (out_item_t)
//
// one item per cycle sustained while res_stall is low; a taken item is held in the input register, then
// the calendar state updates as the item moves from the input register to the result
// reset puts the time at year 0, january 1, 00:00:00, sunday
// src_stall rises only when both registers are full and res_stall is high
`default_nettype none

module calendar_time_counter (
    input  var logic              clk,
    input  var logic              rst_n,
    input  var logic              src_valid,
    output logic                  src_stall,
    input  var ctc_pkg::in_item_t src_item,
    output logic                  res_valid,
    input  var logic              res_stall,
    output ctc_pkg::out_item_t    res_item
);
    import ctc_pkg::*;

    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t res_item_reg;
    logic      res_valid_reg;
    time_t     time_reg;
    time_t     time_next;
    logic [FLAG_W-1:0] flags_next;
    logic      res_free;
    logic      advance;
    logic      take;

    assign res_free  = !res_valid_reg || !res_stall;
    assign advance   = in_valid_reg && res_free;
    assign src_stall = in_valid_reg && !res_free;
    assign take      = src_valid && !src_stall;

    ctc_step u_step (
        .cur   (time_reg),
        .item  (in_item_reg),
        .nxt   (time_next),
        .flags (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            time_reg      <= TIME_RESET;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
            if (advance)
                time_reg <= time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= src_item;
        if (advance)
        begin
            res_item_reg.year_now      <= time_next.year;
            res_item_reg.month_now     <= time_next.month;
            res_item_reg.day_now       <= time_next.day;
            res_item_reg.hour_now      <= time_next.hour;
            res_item_reg.minute_now    <= time_next.minute;
            res_item_reg.second_now    <= time_next.second;
            res_item_reg.weekday_now   <= time_next.weekday;
            res_item_reg.changed_flags <= flags_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // the second flag is set on every item
    a_sec_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.changed_flags[FLAG_SEC])
        else $error("second flag clear on a result");

    // carries form an unbroken run from the second upward
    a_flag_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_item.changed_flags
                        & (res_item.changed_flags + 6'd1)) == 6'd0))
        else $error("changed flags not contiguous");

    // the emitted time is the stored time
    a_state_echo: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (time_reg.second == res_item.second_now)
                    && (time_reg.day == res_item.day_now)
                    && (time_reg.year == res_item.year_now))
        else $error("result time differs from calendar state");

endmodule

`default_nettype wire
